// ===== src/scc_pkg.sv =====
// shared types, widths and constants for the segmentation confusion counter
package scc_pkg;

   localparam int PAL_SLOTS       = 6;
   localparam int COLOR_W         = 24;
   localparam int CLS_W           = 3;
   localparam int OUT_W           = 32;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;
   localparam int NUM_CLASSES_DEF = 6;
   localparam int COUNT_BITS_DEF  = 32;

   typedef logic [COLOR_W-1:0] color_type;

   localparam color_type PAL_RESET [PAL_SLOTS] = '{
      24'hFFFFFF, 24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF
   };

   typedef struct packed {
      color_type reference_color;
      color_type predicted_color;
      logic      final_pixel;
   } req_type;

   typedef struct packed {
      logic [CLS_W-1:0] reference_class;
      logic [OUT_W-1:0] count_as_class_0;
      logic [OUT_W-1:0] count_as_class_1;
      logic [OUT_W-1:0] count_as_class_2;
      logic [OUT_W-1:0] count_as_class_3;
      logic [OUT_W-1:0] count_as_class_4;
      logic [OUT_W-1:0] count_as_class_5;
      logic [OUT_W-1:0] true_positives;
      logic [OUT_W-1:0] false_positives;
      logic [OUT_W-1:0] false_negatives;
      logic             last_row;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD,
      ST_DRAIN,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_EMIT
   } state_type;

endpackage

// ===== src/segmentation_confusion_counter.sv =====
// segmentation confusion counter: palette match, counter memory and row readout
//
// A pixel pair is taken with start while busy is low. Both colors are matched
// against the palette; the highest matching index wins, no match gives class 0.
// The counts live in one synchronous memory (matrix cells, then TP, FP and FN
// per class) and are bumped read-modify-write, saturating, one entry a cycle.
// A pixel takes two reads through the single read port when its classes agree
// and three when they differ, plus the trailing write.
// On a pixel flagged final, the pixel is counted, then NUM_CLASSES rows are read
// out, NUM_CLASSES+3 memory reads each; each row is shown on rsp_payload with
// rsp_strobe high for one cycle, last_row on the last.
// The receiver cannot hold rows off. After the last row all counts clear at
// once through per-entry valid bits, so no clearing pass is needed.
// Palette registers sit on the csr port at byte address 4*i. The user must
// write them only while the block is idle; the block does not enforce it.
// Reset returns the palette to its default colors, zeroes all counts and
// aborts any readout in progress.
module segmentation_confusion_counter #(
   parameter int NUM_CLASSES = scc_pkg::NUM_CLASSES_DEF,
   parameter int COUNT_BITS  = scc_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  scc_pkg::req_type                 req_payload,
   output logic                             rsp_strobe,
   output scc_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [scc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [scc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [scc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int DEPTH   = NUM_CLASSES * NUM_CLASSES + 3 * NUM_CLASSES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SLOTS   = NUM_CLASSES + 3;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int TP_BASE = NUM_CLASSES * NUM_CLASSES;
   localparam int FP_BASE = TP_BASE + NUM_CLASSES;
   localparam int FN_BASE = FP_BASE + NUM_CLASSES;
   localparam int EXT_W   = (COUNT_BITS > scc_pkg::OUT_W) ? COUNT_BITS : scc_pkg::OUT_W;
   localparam int CLS_W   = scc_pkg::CLS_W;
   localparam int OUT_W   = scc_pkg::OUT_W;

   // palette registers
   scc_pkg::color_type pal_ff [scc_pkg::PAL_SLOTS];
   logic [2:0]         csr_idx;
   logic               csr_wr;

   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scc_pkg::PAL_SLOTS; i++) begin
            pal_ff[i] <= scc_pkg::PAL_RESET[i];
         end
      end else if (csr_wr && csr_idx < 3'(scc_pkg::PAL_SLOTS)) begin
         pal_ff[csr_idx] <= csr_pwdata[scc_pkg::COLOR_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx < 3'(scc_pkg::PAL_SLOTS)) begin
         csr_prdata = scc_pkg::CSR_DATA_W'(pal_ff[csr_idx]);
      end
   end

   // class match, highest index wins
   logic [CLS_W-1:0] ref_cls;
   logic [CLS_W-1:0] pred_cls;

   always_comb begin
      ref_cls  = '0;
      pred_cls = '0;
      for (int i = 0; i < scc_pkg::PAL_SLOTS; i++) begin
         if (i < NUM_CLASSES && pal_ff[i] == req_payload.reference_color) begin
            ref_cls = CLS_W'(i);
         end
         if (i < NUM_CLASSES && pal_ff[i] == req_payload.predicted_color) begin
            pred_cls = CLS_W'(i);
         end
      end
   end

   // control state
   scc_pkg::state_type state_ff, state_in;
   logic [CLS_W-1:0]   ref_ff, ref_in;
   logic [CLS_W-1:0]   pred_ff, pred_in;
   logic               final_ff, final_in;
   logic [1:0]         op_ff, op_in;
   logic [CLS_W-1:0]   row_ff, row_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic               accept;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               upd_issue;
   logic               cap_issue;
   logic               clr_all;
   logic               last_op;

   assign busy   = !(state_ff == scc_pkg::ST_IDLE ||
                     (state_ff == scc_pkg::ST_DRAIN && !final_ff));
   assign accept = start & ~busy;

   always_comb begin
      state_in   = state_ff;
      ref_in     = ref_ff;
      pred_in    = pred_ff;
      final_in   = final_ff;
      op_in      = op_ff;
      row_in     = row_ff;
      slot_in    = slot_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      upd_issue  = 1'b0;
      cap_issue  = 1'b0;
      clr_all    = 1'b0;
      rsp_strobe = 1'b0;
      last_op    = (op_ff == 2'd1 && ref_ff == pred_ff) || op_ff == 2'd2;

      unique case (state_ff)
         scc_pkg::ST_IDLE: begin
         end
         scc_pkg::ST_UPD: begin
            rd_en     = 1'b1;
            upd_issue = 1'b1;
            unique case (op_ff)
               2'd0: rd_addr = ADDR_W'(ref_ff * NUM_CLASSES + pred_ff);
               2'd1: rd_addr = (ref_ff == pred_ff) ? ADDR_W'(TP_BASE + ref_ff)
                                                   : ADDR_W'(FN_BASE + ref_ff);
               2'd2: rd_addr = ADDR_W'(FP_BASE + pred_ff);
               default: rd_addr = '0;
            endcase
            if (last_op) begin
               state_in = scc_pkg::ST_DRAIN;
            end else begin
               op_in = op_ff + 2'd1;
            end
         end
         scc_pkg::ST_DRAIN: begin
            // last write of the pixel lands at the end of this cycle
            if (final_ff) begin
               state_in = scc_pkg::ST_ROW_RD;
               row_in   = '0;
               slot_in  = '0;
            end else begin
               state_in = scc_pkg::ST_IDLE;
            end
         end
         scc_pkg::ST_ROW_RD: begin
            rd_en     = 1'b1;
            cap_issue = 1'b1;
            priority if (slot_ff < SLOT_W'(NUM_CLASSES)) begin
               rd_addr = ADDR_W'(row_ff * NUM_CLASSES + slot_ff);
            end else if (slot_ff == SLOT_W'(NUM_CLASSES)) begin
               rd_addr = ADDR_W'(TP_BASE + row_ff);
            end else if (slot_ff == SLOT_W'(NUM_CLASSES + 1)) begin
               rd_addr = ADDR_W'(FP_BASE + row_ff);
            end else begin
               rd_addr = ADDR_W'(FN_BASE + row_ff);
            end
            if (slot_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = scc_pkg::ST_ROW_WAIT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         scc_pkg::ST_ROW_WAIT: begin
            state_in = scc_pkg::ST_EMIT;
         end
         scc_pkg::ST_EMIT: begin
            rsp_strobe = 1'b1;
            if (row_ff == CLS_W'(NUM_CLASSES - 1)) begin
               clr_all  = 1'b1;
               state_in = scc_pkg::ST_IDLE;
            end else begin
               row_in   = row_ff + 1'b1;
               slot_in  = '0;
               state_in = scc_pkg::ST_ROW_RD;
            end
         end
         default: begin
            state_in = scc_pkg::ST_IDLE;
         end
      endcase

      if (accept) begin
         ref_in   = ref_cls;
         pred_in  = pred_cls;
         final_in = req_payload.final_pixel;
         op_in    = '0;
         state_in = scc_pkg::ST_UPD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::ST_IDLE;
         ref_ff   <= '0;
         pred_ff  <= '0;
         final_ff <= 1'b0;
         op_ff    <= '0;
         row_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ref_ff   <= ref_in;
         pred_ff  <= pred_in;
         final_ff <= final_in;
         op_ff    <= op_in;
         row_ff   <= row_in;
         slot_ff  <= slot_in;
      end
   end

   // counter memory with valid bits; an invalid entry reads as zero
   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  rvalid_ff;
   logic                  upd_pend_ff;
   logic [ADDR_W-1:0]     upd_addr_ff;
   logic                  cap_en_ff;
   logic [SLOT_W-1:0]     cap_slot_ff;
   logic [COUNT_BITS-1:0] rd_value;
   logic [COUNT_BITS-1:0] inc_value;
   logic [EXT_W-1:0]      ext_value;
   logic [OUT_W-1:0]      clamp_value;

   assign rd_value    = rvalid_ff ? rdata_ff : '0;
   assign inc_value   = (&rd_value) ? rd_value : rd_value + 1'b1;
   assign ext_value   = EXT_W'(rd_value);
   assign clamp_value = (ext_value > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                          : ext_value[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      if (upd_pend_ff) begin
         mem[upd_addr_ff] <= inc_value;
      end
   end

   always_ff @(posedge clock) begin
      upd_addr_ff <= rd_addr;
      cap_slot_ff <= slot_ff;
      if (rd_en) begin
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         valid_ff <= '0;
      end else if (upd_pend_ff) begin
         valid_ff[upd_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_pend_ff <= 1'b0;
         cap_en_ff   <= 1'b0;
      end else begin
         upd_pend_ff <= upd_issue;
         cap_en_ff   <= cap_issue;
      end
   end

   // row buffer filled slot by slot during readout
   logic [OUT_W-1:0] rowbuf_ff [SLOTS];
   logic [OUT_W-1:0] col_cnt [scc_pkg::PAL_SLOTS];

   always_ff @(posedge clock) begin
      if (cap_en_ff) begin
         rowbuf_ff[cap_slot_ff] <= clamp_value;
      end
   end

   always_comb begin
      for (int j = 0; j < scc_pkg::PAL_SLOTS; j++) begin
         col_cnt[j] = '0;
         if (j < NUM_CLASSES) begin
            col_cnt[j] = rowbuf_ff[j];
         end
      end
      rsp_payload.reference_class  = row_ff;
      rsp_payload.count_as_class_0 = col_cnt[0];
      rsp_payload.count_as_class_1 = col_cnt[1];
      rsp_payload.count_as_class_2 = col_cnt[2];
      rsp_payload.count_as_class_3 = col_cnt[3];
      rsp_payload.count_as_class_4 = col_cnt[4];
      rsp_payload.count_as_class_5 = col_cnt[5];
      rsp_payload.true_positives   = rowbuf_ff[NUM_CLASSES];
      rsp_payload.false_positives  = rowbuf_ff[NUM_CLASSES + 1];
      rsp_payload.false_negatives  = rowbuf_ff[NUM_CLASSES + 2];
      rsp_payload.last_row         = (row_ff == CLS_W'(NUM_CLASSES - 1));
   end

endmodule

// ===== src/scc_checker.sv =====
// port-level checks for the segmentation confusion counter, bound to the top level
module scc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input scc_pkg::rsp_type rsp_payload
);

   // an accepted pixel always keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a pixel");

   // rows appear only during a readout
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat while idle");

   // each row takes several memory reads, so beats never come back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beats in consecutive cycles");

   // after the last row the block is free again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.last_row |=> !busy)
      else $error("block still busy after last row");

endmodule

bind segmentation_confusion_counter scc_checker u_scc_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

// ===== bench/segmentation_confusion_counter_test.sv =====
// testbench for the segmentation confusion counter: palette setup, pixel stream, row checks
`timescale 1ns / 100ps

module segmentation_confusion_counter_test;

   localparam int CLASSES    = scc_pkg::NUM_CLASSES_DEF;
   localparam int REG_STRIDE = 4;
   localparam int UNUSED_REG = scc_pkg::PAL_SLOTS;   // first index past the palette
   localparam int LAST_REG   = 7;                    // highest index the address reaches
   localparam int TAIL_WAIT  = 12;
   localparam int DRAIN_WAIT = 80;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   scc_pkg::req_type               req_payload = '0;
   logic                           rsp_strobe;
   scc_pkg::rsp_type               rsp_payload;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [scc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [scc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [scc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // shadow of the palette and the counts
   scc_pkg::color_type palette_copy [scc_pkg::PAL_SLOTS];
   logic [31:0]        cell_count [CLASSES][CLASSES];
   logic [31:0]        tp_count [CLASSES];
   logic [31:0]        fp_count [CLASSES];
   logic [31:0]        fn_count [CLASSES];
   scc_pkg::rsp_type   expected_rows [$];

   int unsigned mismatches = 0;
   int unsigned pixels_sent = 0;
   int unsigned images_sent = 0;
   int unsigned rows_checked = 0;
   int unsigned burst_left = 0;
   bit          gaps_on = 1'b1;

   segmentation_confusion_counter dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 40)
         $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int unsigned row,
                              input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("row %0d %s: got %h want %h", row, name, got, want));
   endtask

   function automatic int unsigned color_class(input scc_pkg::color_type c);
      int unsigned cls;
      cls = 0;
      for (int i = 0; i < CLASSES; i++)
         if (palette_copy[i] == c)
            cls = i;
      return cls;
   endfunction

   function automatic logic [31:0] bumped(input logic [31:0] v);
      return (v == '1) ? v : v + 1;
   endfunction

   task automatic clear_counts();
      for (int k = 0; k < CLASSES; k++) begin
         for (int j = 0; j < CLASSES; j++)
            cell_count[k][j] = '0;
         tp_count[k] = '0;
         fp_count[k] = '0;
         fn_count[k] = '0;
      end
   endtask

   // counts one accepted pixel and queues the readout rows on a final one
   task automatic tally_pixel(input scc_pkg::req_type px);
      int unsigned      ref_cls;
      int unsigned      pred_cls;
      scc_pkg::rsp_type row;
      ref_cls = color_class(px.reference_color);
      pred_cls = color_class(px.predicted_color);
      cell_count[ref_cls][pred_cls] = bumped(cell_count[ref_cls][pred_cls]);
      if (ref_cls == pred_cls) begin
         tp_count[ref_cls] = bumped(tp_count[ref_cls]);
      end else begin
         fn_count[ref_cls] = bumped(fn_count[ref_cls]);
         fp_count[pred_cls] = bumped(fp_count[pred_cls]);
      end
      if (px.final_pixel) begin
         for (int k = 0; k < CLASSES; k++) begin
            row.reference_class  = k[scc_pkg::CLS_W-1:0];
            row.count_as_class_0 = cell_count[k][0];
            row.count_as_class_1 = cell_count[k][1];
            row.count_as_class_2 = cell_count[k][2];
            row.count_as_class_3 = cell_count[k][3];
            row.count_as_class_4 = cell_count[k][4];
            row.count_as_class_5 = cell_count[k][5];
            row.true_positives   = tp_count[k];
            row.false_positives  = fp_count[k];
            row.false_negatives  = fn_count[k];
            row.last_row         = (k == CLASSES - 1);
            expected_rows.push_back(row);
         end
         clear_counts();
         images_sent++;
      end
   endtask

   // called right after a rising edge; leaves start high for a following beat
   task automatic send_pixel(input scc_pkg::color_type ref_color,
                             input scc_pkg::color_type pred_color,
                             input logic fin);
      scc_pkg::req_type px;
      if (gaps_on && burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 10);
      end
      if (burst_left > 0)
         burst_left--;
      px.reference_color = ref_color;
      px.predicted_color = pred_color;
      px.final_pixel = fin;
      start <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (busy);
      tally_pixel(px);
      pixels_sent++;
   endtask

   // let everything queued drain and the block go quiet before touching registers
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_rows.size() != 0 || busy)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic write_palette(input int unsigned index, input logic [31:0] data);
      logic [scc_pkg::CSR_ADDR_W-1:0] addr;
      logic [scc_pkg::CSR_DATA_W-1:0] want;
      addr = scc_pkg::CSR_ADDR_W'(index * REG_STRIDE);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index < scc_pkg::PAL_SLOTS)
         palette_copy[index] = data[scc_pkg::COLOR_W-1:0];
      // the register reads back in the cycle after the access beat
      @(posedge clock);
      if (index < scc_pkg::PAL_SLOTS) begin
         want = scc_pkg::CSR_DATA_W'(palette_copy[index]);
         if (csr_prdata !== want)
            report_mismatch($sformatf("palette %0d read back %h want %h",
                                      index, csr_prdata, want));
      end
   endtask

   // mostly palette colors, some near misses and some noise
   function automatic scc_pkg::color_type pick_color();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return palette_copy[$urandom_range(0, scc_pkg::PAL_SLOTS - 1)];
      else if (roll < 90)
         return palette_copy[$urandom_range(0, scc_pkg::PAL_SLOTS - 1)] ^
                (24'h1 << $urandom_range(0, 23));
      else
         return scc_pkg::color_type'($urandom());
   endfunction

   task automatic test_default_palette();
      for (int i = 0; i < scc_pkg::PAL_SLOTS; i++)
         send_pixel(scc_pkg::PAL_RESET[i], scc_pkg::PAL_RESET[i], 1'b0);
      send_pixel(scc_pkg::PAL_RESET[1], scc_pkg::PAL_RESET[4], 1'b0);
      // unmatched colors fall into class 0
      send_pixel(24'h123456, scc_pkg::PAL_RESET[3], 1'b0);
      send_pixel(24'h000000, 24'hFFFFFE, 1'b0);
      send_pixel(scc_pkg::PAL_RESET[2], 24'h000000, 1'b0);
      send_pixel(scc_pkg::PAL_RESET[5], 24'hABCDEF, 1'b1);
      wait_idle();
   endtask

   task automatic test_palette_writes();
      write_palette(0, 32'hFF000000);       // upper bits dropped, color 0
      write_palette(1, 32'h00FFFFFF);
      write_palette(2, 32'h005A5A5A);
      write_palette(3, 32'h00A5A5A5);
      write_palette(4, 32'h00FFFFFF);       // same as class 1, class 4 wins
      write_palette(5, 32'h00000001);
      write_palette(UNUSED_REG, 32'h00777777);
      write_palette(LAST_REG, 32'h00888888);
      send_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 24'h000001, 1'b0);
      send_pixel(24'h777777, 24'h5A5A5A, 1'b0);
      send_pixel(24'h888888, 24'h888888, 1'b0);
      send_pixel(24'hA5A5A5, 24'hFFFFFF, 1'b0);
      send_pixel(24'h000001, 24'hA5A5A5, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_images(input int unsigned phases, input int unsigned per_phase);
      scc_pkg::color_type choices [3];
      int unsigned        pick;
      for (int p = 0; p < phases; p++) begin
         gaps_on = (p % 4 != 2);
         for (int c = 0; c < 3; c++)
            choices[c] = scc_pkg::color_type'($urandom());
         for (int i = 0; i < scc_pkg::PAL_SLOTS; i++) begin
            unique case (p % 4)
               0: write_palette(i, $urandom());
               1: write_palette(i, {8'h00, choices[$urandom_range(0, 2)]});
               2: write_palette(i, {8'h00, scc_pkg::PAL_RESET[i]});
               default: begin
                  pick = $urandom_range(0, 2);
                  write_palette(i, pick == 0 ? 32'h0 : pick == 1 ? 32'h00FFFFFF : $urandom());
               end
            endcase
         end
         if ($urandom_range(0, 1))
            write_palette($urandom_range(UNUSED_REG, LAST_REG), $urandom());
         for (int n = 0; n < per_phase; n++)
            send_pixel(pick_color(), pick_color(),
                       (n == per_phase - 1) || ($urandom_range(0, 9) == 0));
         wait_idle();
      end
   endtask

   always @(posedge clock) begin : row_check
      scc_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rows.size() == 0) begin
            report_mismatch($sformatf("row with no readout pending, class %0d",
                                      rsp_payload.reference_class));
         end else begin
            want = expected_rows.pop_front();
            check_field("reference_class", rows_checked, 32'(rsp_payload.reference_class),
                        32'(want.reference_class));
            check_field("count_as_class_0", rows_checked, rsp_payload.count_as_class_0,
                        want.count_as_class_0);
            check_field("count_as_class_1", rows_checked, rsp_payload.count_as_class_1,
                        want.count_as_class_1);
            check_field("count_as_class_2", rows_checked, rsp_payload.count_as_class_2,
                        want.count_as_class_2);
            check_field("count_as_class_3", rows_checked, rsp_payload.count_as_class_3,
                        want.count_as_class_3);
            check_field("count_as_class_4", rows_checked, rsp_payload.count_as_class_4,
                        want.count_as_class_4);
            check_field("count_as_class_5", rows_checked, rsp_payload.count_as_class_5,
                        want.count_as_class_5);
            check_field("true_positives", rows_checked, rsp_payload.true_positives,
                        want.true_positives);
            check_field("false_positives", rows_checked, rsp_payload.false_positives,
                        want.false_positives);
            check_field("false_negatives", rows_checked, rsp_payload.false_negatives,
                        want.false_negatives);
            check_field("last_row", rows_checked, 32'(rsp_payload.last_row),
                        32'(want.last_row));
            rows_checked++;
         end
      end
   end

   initial begin
      for (int i = 0; i < scc_pkg::PAL_SLOTS; i++)
         palette_copy[i] = scc_pkg::PAL_RESET[i];
      clear_counts();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_palette();
      test_palette_writes();
      test_random_images(4, 60);

      start <= 1'b0;
      while (expected_rows.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_rows.size() != 0)
         report_mismatch($sformatf("%0d rows never arrived", expected_rows.size()));

      $display("%0d pixel pairs sent, %0d images read out, %0d rows checked",
               pixels_sent, images_sent, rows_checked);
      $display("covered default and rewritten palettes, duplicate and missing matches, %s",
               "unused register writes, register readback and back-to-back pixels");
      if (mismatches == 0) begin
         $display("segmentation_confusion_counter_test: PASS");
      end else begin
         $display("segmentation_confusion_counter_test: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout at %0t", $time);
      $display("segmentation_confusion_counter_test: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/scc_pkg.sv
src/segmentation_confusion_counter.sv
src/scc_checker.sv
bench/segmentation_confusion_counter_test.sv
